>>> rtl/flat_json_object_parser_top_defines.svh
// ----------------------------------------------------------------------------
// flat json object parser assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef FLAT_JSON_OBJECT_PARSER_TOP_DEFINES_SVH
`define FLAT_JSON_OBJECT_PARSER_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define FJOP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define FJOP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fjop_pkg.sv
// ----------------------------------------------------------------------------
// fjop_pkg
// types and constants shared by the flat json object parser
// ----------------------------------------------------------------------------
package fjop_pkg;

    // result kinds
    localparam logic [2:0] KIND_KEY   = 3'd0;
    localparam logic [2:0] KIND_STR   = 3'd1;
    localparam logic [2:0] KIND_RAW   = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_VALID = 3'd4;
    localparam logic [2:0] KIND_BAD   = 3'd5;
    localparam logic [2:0] KIND_BLANK = 3'd6;

    // utf-8 encoding constants
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK6 = 8'h3F;
    localparam logic [15:0] CP_ONE_MAX = 16'h0080;
    localparam logic [15:0] CP_TWO_MAX = 16'h0800;

    // results caused by one input byte; all share one kind
    typedef struct packed {
        logic [2:0]      kind;
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
    } t_cmd;

endpackage

>>> rtl/flat_json_object_parser_top.sv
// a byte's first result is registered in the queue, then in the sequencer
// throughput: one byte per cycle, output ready, at most one result per byte
// a byte closing a \u escape yields up to three results and holds the output
// sequencer for each of them; the command queue absorbs the bytes behind it
// reset: synchronous, active low; clears parse state, queue and output valid
// ----------------------------------------------------------------------------
// flat_json_object_parser_top
// line checker and decoder for one flat json object per line
// ----------------------------------------------------------------------------
module flat_json_object_parser_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_line,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_kind,
    output logic       o_last
);

    fjop_pkg::t_cmd w_push_cmd;
    fjop_pkg::t_cmd w_head_cmd;
    logic           w_push, w_pop, w_empty, w_full;

    fjop_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ch    (i_ch),
        .i_eol   (i_end_of_line),
        .i_space (~w_full),
        .o_ready (o_ready),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    fjop_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    fjop_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_head_cmd),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

endmodule

>>> rtl/fjop_front.sv
// ----------------------------------------------------------------------------
// fjop_front
// byte classifier and parse state machine; emits at most one command per byte
// ----------------------------------------------------------------------------
module fjop_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_ch,
    input  logic           i_eol,
    input  logic           i_space,
    output logic           o_ready,
    output logic           o_push,
    output fjop_pkg::t_cmd o_cmd
);

    typedef enum logic [14:0] {
        PH_WAIT_OPEN    = 15'b000000000000001,
        PH_AFTER_OPEN   = 15'b000000000000010,
        PH_EXPECT_KEY   = 15'b000000000000100,
        PH_IN_KEY       = 15'b000000000001000,
        PH_ESC_KEY      = 15'b000000000010000,
        PH_HEX_KEY      = 15'b000000000100000,
        PH_EXPECT_COLON = 15'b000000001000000,
        PH_EXPECT_VAL   = 15'b000000010000000,
        PH_IN_STR       = 15'b000000100000000,
        PH_ESC_STR      = 15'b000001000000000,
        PH_HEX_STR      = 15'b000010000000000,
        PH_IN_RAW       = 15'b000100000000000,
        PH_AFTER_VAL    = 15'b001000000000000,
        PH_AFTER_CLOSE  = 15'b010000000000000,
        PH_ERROR        = 15'b100000000000000
    } t_phase;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    t_phase      r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_seen, n_seen;
    logic        r_nonblank, n_nonblank;

    logic           w_accept;
    logic           w_ws;
    logic           w_key;
    logic [2:0]     w_skind;
    logic [4:0]     w_hex;
    logic [15:0]    w_acc_shift;
    logic           n_emit;
    fjop_pkg::t_cmd n_cmd;

    function automatic fjop_pkg::t_cmd one_cmd(input logic [2:0] kind, input logic [7:0] b);
        fjop_pkg::t_cmd c;
        c          = '0;
        c.kind     = kind;
        c.cnt      = 2'd1;
        c.bytes[0] = b;
        return c;
    endfunction

    function automatic fjop_pkg::t_cmd utf8_cmd(input logic [15:0] cp, input logic [2:0] kind);
        fjop_pkg::t_cmd c;
        c      = '0;
        c.kind = kind;
        if (cp < fjop_pkg::CP_ONE_MAX) begin
            c.cnt      = 2'd1;
            c.bytes[0] = cp[7:0];
        end else if (cp < fjop_pkg::CP_TWO_MAX) begin
            c.cnt      = 2'd2;
            c.bytes[0] = fjop_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            c.bytes[1] = fjop_pkg::UTF8_CONT | (fjop_pkg::UTF8_MASK6 & {2'b00, cp[5:0]});
        end else begin
            c.cnt      = 2'd3;
            c.bytes[0] = fjop_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
            c.bytes[1] = fjop_pkg::UTF8_CONT | (fjop_pkg::UTF8_MASK6 & {2'b00, cp[11:6]});
            c.bytes[2] = fjop_pkg::UTF8_CONT | (fjop_pkg::UTF8_MASK6 & {2'b00, cp[5:0]});
        end
        return c;
    endfunction

    // {invalid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
        else                               v = 5'b10000;
        return v;
    endfunction

    assign o_ready     = i_space;
    assign w_accept    = i_valid & o_ready;
    assign w_ws        = (i_ch == CH_SPACE) || (i_ch == CH_TAB) ||
                         (i_ch == CH_CR) || (i_ch == CH_LF);
    assign w_key       = (r_phase == PH_IN_KEY) || (r_phase == PH_ESC_KEY) ||
                         (r_phase == PH_HEX_KEY);
    assign w_skind     = w_key ? fjop_pkg::KIND_KEY : fjop_pkg::KIND_STR;
    assign w_hex       = hex_val(i_ch);
    assign w_acc_shift = {r_acc[11:0], w_hex[3:0]};

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_seen     = r_seen;
        n_nonblank = r_nonblank;
        n_emit     = 1'b0;
        n_cmd      = '0;
        if (w_accept) begin
            if (i_eol) begin
                n_emit = 1'b1;
                if (r_phase == PH_AFTER_CLOSE) n_cmd = one_cmd(fjop_pkg::KIND_VALID, 8'h00);
                else if (!r_nonblank)          n_cmd = one_cmd(fjop_pkg::KIND_BLANK, 8'h00);
                else                           n_cmd = one_cmd(fjop_pkg::KIND_BAD, 8'h00);
                n_phase    = PH_WAIT_OPEN;
                n_acc      = '0;
                n_seen     = '0;
                n_nonblank = 1'b0;
            end else begin
                if (i_ch != CH_SPACE && i_ch != CH_TAB) n_nonblank = 1'b1;
                case (r_phase)
                    PH_WAIT_OPEN: begin
                        if (i_ch == CH_LBRACE) n_phase = PH_AFTER_OPEN;
                        else if (!w_ws)        n_phase = PH_ERROR;
                    end
                    PH_AFTER_OPEN, PH_EXPECT_KEY: begin
                        if (i_ch == CH_QUOTE) n_phase = PH_IN_KEY;
                        else if (i_ch == CH_RBRACE && r_phase == PH_AFTER_OPEN)
                            n_phase = PH_AFTER_CLOSE;
                        else if (!w_ws) n_phase = PH_ERROR;
                    end
                    PH_IN_KEY, PH_IN_STR: begin
                        if (i_ch == CH_QUOTE) begin
                            if (w_key) begin
                                n_phase = PH_EXPECT_COLON;
                            end else begin
                                n_emit  = 1'b1;
                                n_cmd   = one_cmd(fjop_pkg::KIND_DONE, 8'h00);
                                n_phase = PH_AFTER_VAL;
                            end
                        end else if (i_ch == CH_BSLASH) begin
                            n_phase = w_key ? PH_ESC_KEY : PH_ESC_STR;
                        end else begin
                            n_emit = 1'b1;
                            n_cmd  = one_cmd(w_skind, i_ch);
                        end
                    end
                    PH_ESC_KEY, PH_ESC_STR: begin
                        n_emit  = 1'b1;
                        n_phase = w_key ? PH_IN_KEY : PH_IN_STR;
                        case (i_ch)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: n_cmd = one_cmd(w_skind, i_ch);
                            CH_LC_B: n_cmd = one_cmd(w_skind, CH_BS);
                            CH_LC_F: n_cmd = one_cmd(w_skind, CH_FF);
                            CH_LC_N: n_cmd = one_cmd(w_skind, CH_LF);
                            CH_LC_R: n_cmd = one_cmd(w_skind, CH_CR);
                            CH_LC_T: n_cmd = one_cmd(w_skind, CH_TAB);
                            CH_LC_U: begin
                                n_emit  = 1'b0;
                                n_acc   = '0;
                                n_seen  = '0;
                                n_phase = w_key ? PH_HEX_KEY : PH_HEX_STR;
                            end
                            default: begin
                                n_emit  = 1'b0;
                                n_phase = PH_ERROR;
                            end
                        endcase
                    end
                    PH_HEX_KEY, PH_HEX_STR: begin
                        if (w_hex[4]) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_acc = w_acc_shift;
                            if (r_seen == 2'd3) begin
                                n_seen  = '0;
                                n_phase = w_key ? PH_IN_KEY : PH_IN_STR;
                                n_emit  = 1'b1;
                                n_cmd   = utf8_cmd(w_acc_shift, w_skind);
                            end else begin
                                n_seen = r_seen + 2'd1;
                            end
                        end
                    end
                    PH_EXPECT_COLON: begin
                        if (i_ch == CH_COLON) n_phase = PH_EXPECT_VAL;
                        else if (!w_ws)       n_phase = PH_ERROR;
                    end
                    PH_EXPECT_VAL: begin
                        if (!w_ws) begin
                            if (i_ch == CH_QUOTE) begin
                                n_phase = PH_IN_STR;
                            end else if (i_ch == CH_LBRACE || i_ch == CH_LBRACK ||
                                         i_ch == CH_COMMA || i_ch == CH_RBRACE) begin
                                n_phase = PH_ERROR;
                            end else begin
                                n_emit  = 1'b1;
                                n_cmd   = one_cmd(fjop_pkg::KIND_RAW, i_ch);
                                n_phase = PH_IN_RAW;
                            end
                        end
                    end
                    PH_IN_RAW: begin
                        n_emit = 1'b1;
                        if (i_ch == CH_COMMA || i_ch == CH_RBRACE || w_ws) begin
                            n_cmd = one_cmd(fjop_pkg::KIND_DONE, 8'h00);
                            if (i_ch == CH_COMMA)       n_phase = PH_EXPECT_KEY;
                            else if (i_ch == CH_RBRACE) n_phase = PH_AFTER_CLOSE;
                            else                        n_phase = PH_AFTER_VAL;
                        end else begin
                            n_cmd = one_cmd(fjop_pkg::KIND_RAW, i_ch);
                        end
                    end
                    PH_AFTER_VAL: begin
                        if (i_ch == CH_COMMA)       n_phase = PH_EXPECT_KEY;
                        else if (i_ch == CH_RBRACE) n_phase = PH_AFTER_CLOSE;
                        else if (!w_ws)             n_phase = PH_ERROR;
                    end
                    PH_AFTER_CLOSE: begin
                        if (!w_ws) n_phase = PH_ERROR;
                    end
                    default: begin
                        n_phase = PH_ERROR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT_OPEN;
            r_acc      <= '0;
            r_seen     <= '0;
            r_nonblank <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_seen     <= n_seen;
            r_nonblank <= n_nonblank;
        end
    end

    assign o_push = n_emit;
    assign o_cmd  = n_cmd;

endmodule

>>> rtl/fjop_fifo.sv
// ----------------------------------------------------------------------------
// fjop_fifo
// small command queue between the parser and the output sequencer
// ----------------------------------------------------------------------------
module fjop_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fjop_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output fjop_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    fjop_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, n_wptr;
    logic [AW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           w_wr, w_rd;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + AW'(1);
        if (w_rd) n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + AW'(1);
        if (w_wr && !w_rd)      n_cnt = r_cnt + CW'(1);
        else if (w_rd && !w_wr) n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

>>> rtl/fjop_back.sv
// ----------------------------------------------------------------------------
// fjop_back
// output sequencer; plays each queued command out, one result per ready cycle
// ----------------------------------------------------------------------------
module fjop_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fjop_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic [2:0]     o_kind,
    output logic           o_last
);

    logic           r_busy, n_busy;
    fjop_pkg::t_cmd r_cmd, n_cmd;
    logic [1:0]     r_idx, n_idx;
    logic           w_fire, w_last, w_advance;

    assign w_fire    = r_busy & i_ready;
    assign w_last    = ((r_idx + 2'd1) == r_cmd.cnt);
    assign w_advance = ~r_busy | (w_fire & w_last);
    assign o_pop     = w_advance & ~i_empty;

    always_comb begin
        n_busy = r_busy;
        n_cmd  = r_cmd;
        n_idx  = r_idx;
        if (w_advance) begin
            // pick up the next transaction group as the current one leaves
            n_busy = ~i_empty;
            n_cmd  = i_cmd;
            n_idx  = '0;
        end else if (w_fire) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_valid    = r_busy;
    assign o_out_byte = r_cmd.bytes[r_idx];
    assign o_kind     = r_cmd.kind;
    assign o_last     = w_last;

endmodule

>>> rtl/fjop_checker.sv
// ----------------------------------------------------------------------------
// fjop_checker
// port-level checks for the flat json object parser, bound to the top level
// ----------------------------------------------------------------------------
`include "flat_json_object_parser_top_defines.svh"

module fjop_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic [2:0] o_kind,
    input logic       o_last
);

    logic        w_stall;
    logic        w_marker;
    logic [11:0] w_result;

    assign w_stall  = o_valid && !i_ready;
    assign w_result = {o_out_byte, o_kind, o_last};
    assign w_marker = o_valid && (o_kind inside {fjop_pkg::KIND_DONE, fjop_pkg::KIND_VALID,
                                                 fjop_pkg::KIND_BAD, fjop_pkg::KIND_BLANK});

    // stalled result holds
    `FJOP_ASSERT_NEXT(a_out_hold, w_stall, o_valid && $stable(w_result), "stalled result changed")

    // markers and verdicts carry a zero byte
    `FJOP_ASSERT_NOW(a_marker_zero, w_marker, o_out_byte == 8'h00, "marker with nonzero byte")

    // markers and verdicts are always alone in their transaction group
    `FJOP_ASSERT_NOW(a_marker_last, w_marker, o_last, "marker result not flagged last")

    // the rest of a multi-byte group follows at once with the same kind
    `FJOP_ASSERT_NEXT(a_group_cont, o_valid && i_ready && !o_last, o_valid && (o_kind == $past(o_kind)), "multi-byte group broken")

endmodule

bind flat_json_object_parser_top fjop_checker u_fjop_checker (.*);
